// ===== hdl/pckm_pkg.sv =====
// Shared types, constants and BCD helpers for the phantom clock key matcher.
package pckm_pkg;

	// Key and readout sizes
	localparam int KeyLen  = 64;
	localparam int CntW    = 7;
	localparam int SentW   = 6;
	localparam int SelBit  = 2;
	localparam int KeyBit  = 0;

	localparam logic [7:0]  KeepHigh = 8'hFE;
	localparam logic [63:0] KeyReset = 64'h5CA33AC55CA33AC5;

	// Opcodes
	localparam logic OpRead  = 1'b0;
	localparam logic OpReset = 1'b1;

	// Configuration register indexes
	localparam logic RegClockEnabled = 1'b0;
	localparam logic RegUnlockKey    = 1'b1;

	// Phase codes
	localparam logic [1:0] PhaseIdle  = 2'd0;
	localparam logic [1:0] PhaseMatch = 2'd1;
	localparam logic [1:0] PhaseRead  = 2'd2;

	typedef struct packed {
		logic        opcode;
		logic [15:0] address;
		logic [7:0]  rom_data;
		logic [5:0]  now_seconds;
		logic [5:0]  now_minutes;
		logic [4:0]  now_hours;
		logic [2:0]  now_weekday;
		logic [4:0]  now_day;
		logic [3:0]  now_month;
		logic [6:0]  now_year;
	} pckm_in_t;

	typedef struct packed {
		logic [7:0] data_out;
		logic [1:0] phase_now;
	} pckm_out_t;

	typedef struct packed {
		logic        clock_enabled;
		logic [63:0] unlock_key;
	} pckm_cfg_t;

	// Binary to BCD byte; tens via multiply by 205/2048, tens digit clamped to 9
	function automatic logic [7:0] bcd_byte(input logic [6:0] v);
		logic [14:0] prod;
		logic [3:0]  tens_raw;
		logic [6:0]  tens_val;
		logic [6:0]  ones;
		logic [3:0]  tens;
		prod     = 15'(v) * 15'd205;
		tens_raw = prod[14:11];
		tens_val = 7'(tens_raw) * 7'd10;
		ones     = v - tens_val;
		tens     = (tens_raw > 4'd9) ? 4'd9 : tens_raw;
		return {tens, ones[3:0]};
	endfunction

	// Time snapshot, centiseconds byte fixed at zero
	function automatic logic [63:0] time_latch(input pckm_in_t it);
		logic [6:0] wday;
		wday = {4'b0, it.now_weekday} + 7'd1;
		return {bcd_byte(it.now_year),
			bcd_byte({3'b0, it.now_month}),
			bcd_byte({2'b0, it.now_day}),
			bcd_byte(wday),
			bcd_byte({2'b0, it.now_hours}),
			bcd_byte({1'b0, it.now_minutes}),
			bcd_byte({1'b0, it.now_seconds}),
			8'h00};
	endfunction

endpackage

// ===== hdl/pckm_in_if.sv =====
// Access channel: valid/ready with one bus access item as payload.
interface pckm_in_if import pckm_pkg::*; ();
	logic     valid;
	logic     ready;
	pckm_in_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ===== hdl/pckm_out_if.sv =====
// Result channel: valid/ready with one result item as payload.
interface pckm_out_if import pckm_pkg::*; ();
	logic      valid;
	logic      ready;
	pckm_out_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ===== hdl/pckm_cfg_regs.sv =====
// Configuration registers: clock enable and unlock key.
module pckm_cfg_regs import pckm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_idx,
	input  logic [63:0] cfg_data,
	output pckm_cfg_t   cfg
);

	logic        clock_enabled_q;
	logic [63:0] unlock_key_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_enabled_q <= 1'b1;
			unlock_key_q    <= KeyReset;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx)
				RegClockEnabled: clock_enabled_q <= cfg_data[0];
				RegUnlockKey:    unlock_key_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.clock_enabled = clock_enabled_q;
	assign cfg.unlock_key    = unlock_key_q;

endmodule

// ===== hdl/pckm_matcher.sv =====
// Key matcher and time readout state, updated once per processed item.
module pckm_matcher import pckm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  pckm_cfg_t cfg,
	input  logic      step,
	input  pckm_in_t  item,
	output pckm_out_t result
);

	logic              open_q, open_n;
	logic              readout_q, readout_n;
	logic [CntW-1:0]   matched_q, matched_n;
	logic [SentW-1:0]  sent_q, sent_n;
	logic [KeyLen-1:0] tsr_q, tsr_n;
	logic              do_adv;
	logic              do_clear;
	logic              want;
	logic [7:0]        data;

	assign want = cfg.unlock_key[matched_q[SentW-1:0]];

	// Next state and data byte for the item in the input stage
	always_comb begin
		open_n    = open_q;
		readout_n = readout_q;
		matched_n = matched_q;
		sent_n    = sent_q;
		tsr_n     = tsr_q;
		do_adv    = 1'b0;
		do_clear  = 1'b0;
		data      = item.rom_data;

		if (item.opcode == OpReset) begin
			do_clear = 1'b1;
			data     = 8'h00;
		end else if (cfg.clock_enabled) begin
			if (item.address[SelBit]) begin
				if (!readout_q) begin
					open_n    = 1'b1;
					matched_n = '0;
				end else begin
					data   = (item.rom_data & KeepHigh) | {7'b0, tsr_q[0]};
					do_adv = 1'b1;
				end
			end else if (open_q) begin
				if (readout_q) begin
					// hidden bit: consumed, not shown
					do_adv = 1'b1;
				end else if (item.address[KeyBit] == want) begin
					matched_n = matched_q + CntW'(1);
					if (matched_q == CntW'(KeyLen - 1)) begin
						tsr_n     = time_latch(item);
						sent_n    = '0;
						readout_n = 1'b1;
					end
				end else begin
					open_n = 1'b0;
				end
			end
		end

		// shift one time bit out; last bit ends readout
		if (do_adv) begin
			tsr_n = tsr_q >> 1;
			if (&sent_q) begin
				do_clear = 1'b1;
			end else begin
				sent_n = sent_q + SentW'(1);
			end
		end

		if (do_clear) begin
			open_n    = 1'b1;
			readout_n = 1'b0;
			matched_n = '0;
			sent_n    = '0;
		end
	end

	// Phase after this item
	always_comb begin
		result.data_out = data;
		if (!cfg.clock_enabled) begin
			result.phase_now = PhaseIdle;
		end else if (readout_n) begin
			result.phase_now = PhaseRead;
		end else if (matched_n != '0) begin
			result.phase_now = PhaseMatch;
		end else begin
			result.phase_now = PhaseIdle;
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q    <= 1'b1;
			readout_q <= 1'b0;
			matched_q <= '0;
			sent_q    <= '0;
			tsr_q     <= '0;
		end else if (step) begin
			open_q    <= open_n;
			readout_q <= readout_n;
			matched_q <= matched_n;
			sent_q    <= sent_n;
			tsr_q     <= tsr_n;
		end
	end

	// Readout only follows a full match with key bits still open
	a_readout_full_match: assert property (@(posedge clk) disable iff (!arst_n)
		readout_q |-> (open_q && matched_q == CntW'(KeyLen)))
		else $error("readout active without a full key match");

	// Outside readout the bit counter rests at zero and the match count stays short
	a_idle_counters: assert property (@(posedge clk) disable iff (!arst_n)
		!readout_q |-> (sent_q == '0 && !matched_q[CntW-1]))
		else $error("counters inconsistent outside readout");

	// A reset event returns the matcher to its start
	a_reset_event: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item.opcode == OpReset) |=> (!readout_q && open_q && matched_q == '0))
		else $error("reset event did not clear the matcher");

	// A reset event drives a zero byte
	a_reset_data: assert property (@(posedge clk) disable iff (!arst_n)
		(item.opcode == OpReset) |-> (result.data_out == 8'h00))
		else $error("reset event data not zero");

endmodule

// ===== hdl/phantom_clock_key_matcher_top.sv =====
// Top level: input stage, key matcher, result register and configuration.
//
//  port       | dir  | handshake    | content
//  -----------+------+--------------+-------------------------------------
//  access     | sink | valid/ready  | opcode, address, rom_data, time now
//  result     | src  | valid/ready  | data_out, phase_now
//  cfg_*      | sink | write enable | cfg_idx selects register, cfg_data
//
// One item per cycle sustained while the result is not stalled. An item is
// registered in the input stage when accepted and moves to the result
// register when the stage advances; its result is offered from there.
// Matcher state is read and written in the single step from input stage
// to result register. arst_n clears the stages, the matcher and loads
// the register defaults. A stalled result holds the result register and
// the input stage; access stays ready while the input stage can drain.
module phantom_clock_key_matcher_top import pckm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	pckm_in_if.sink     access,
	pckm_out_if.source  result,
	input  logic        cfg_wr_en,
	input  logic        cfg_idx,
	input  logic [63:0] cfg_data
);

	pckm_cfg_t cfg;
	pckm_in_t  item_s1;
	logic      valid_s1;
	pckm_out_t step_res;
	pckm_out_t result_s2;
	logic      valid_s2;
	logic      adv;
	logic      take;

	pckm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Stage handshake
	assign adv          = valid_s1 && (!valid_s2 || result.ready);
	assign access.ready = !valid_s1 || adv;
	assign take         = access.valid && access.ready;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= access.payload;
		end
	end

	pckm_matcher u_matcher (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (adv),
		.item   (item_s1),
		.result (step_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_s2 <= step_res;
		end
	end

	assign result.valid   = valid_s2;
	assign result.payload = result_s2;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the phantom clock key matcher: scoreboard, drivers, stimulus.
module tb import pckm_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit  = 200000;
	localparam int DrainCycles = 8;

	// Expected-answer tracker: mirrors the matcher state and queues its answers
	class clock_unlock_board;
		bit        clock_on;
		bit [63:0] key;
		bit        key_open;
		bit        reading;
		bit [6:0]  bits_matched;
		bit [5:0]  bits_sent;
		bit [63:0] time_bits;
		pckm_out_t due_answers[$];
		int        mismatches;

		function new();
			clock_on   = 1'b1;
			key        = KeyReset;
			time_bits  = '0;
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			key_open     = 1'b1;
			reading      = 1'b0;
			bits_matched = '0;
			bits_sent    = '0;
		endfunction

		function void write_reg(logic idx, logic [63:0] val);
			if (idx == RegClockEnabled)
				clock_on = val[0];
			else if (idx == RegUnlockKey)
				key = val;
		endfunction

		// Binary to BCD, tens digit clamped to 9
		function bit [7:0] bcd(int unsigned v);
			int unsigned tens;
			tens = v / 10;
			if (tens > 9)
				tens = 9;
			return {4'(tens), 4'(v % 10)};
		endfunction

		// Snapshot of the time fields; low byte is centiseconds, always zero
		function bit [63:0] latch_time(pckm_in_t it);
			return {bcd(it.now_year), bcd(it.now_month), bcd(it.now_day),
				bcd(it.now_weekday + 1), bcd(it.now_hours), bcd(it.now_minutes),
				bcd(it.now_seconds), 8'h00};
		endfunction

		function void shift_out();
			time_bits = time_bits >> 1;
			if (int'(bits_sent) >= KeyLen - 1)
				restart();
			else
				bits_sent++;
		endfunction

		// Predict the answer for one accepted access item
		function void note_access(pckm_in_t it);
			pckm_out_t ans;
			ans.data_out = it.rom_data;
			if (it.opcode == OpReset) begin
				restart();
				ans.data_out = '0;
			end else if (clock_on) begin
				if (it.address[SelBit]) begin
					if (!reading) begin
						key_open     = 1'b1;
						bits_matched = '0;
					end else begin
						ans.data_out = (it.rom_data & KeepHigh) | 8'(time_bits[0]);
						shift_out();
					end
				end else if (key_open) begin
					if (reading) begin
						// silent read consumes a time bit
						shift_out();
					end else if (it.address[KeyBit] == key[bits_matched[5:0]]) begin
						bits_matched++;
						if (int'(bits_matched) >= KeyLen) begin
							time_bits = latch_time(it);
							bits_sent = '0;
							reading   = 1'b1;
						end
					end else begin
						key_open = 1'b0;
					end
				end
			end
			if (!clock_on)
				ans.phase_now = PhaseIdle;
			else if (reading)
				ans.phase_now = PhaseRead;
			else if (bits_matched != 0)
				ans.phase_now = PhaseMatch;
			else
				ans.phase_now = PhaseIdle;
			due_answers = {due_answers, ans};
		endfunction

		task flag(string what);
			mismatches++;
			$display("[%0t] mismatch: %s", $time, what);
		endtask

		// Compare one result item with the oldest expected answer
		task check_answer(pckm_out_t got);
			pckm_out_t want;
			if (due_answers.size() == 0) begin
				flag($sformatf("unexpected result data_out=%02h phase=%0d",
					got.data_out, got.phase_now));
				return;
			end
			want = due_answers.pop_front();
			if (got.data_out !== want.data_out || got.phase_now !== want.phase_now)
				flag($sformatf("data_out=%02h phase=%0d, expected data_out=%02h phase=%0d",
					got.data_out, got.phase_now, want.data_out, want.phase_now));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en;
	logic        cfg_idx;
	logic [63:0] cfg_data;

	pckm_in_if  access_ch();
	pckm_out_if result_ch();

	phantom_clock_key_matcher_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.access   (access_ch),
		.result   (result_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	clock_unlock_board board = new();
	int gap_pct = 0;
	int stall_pct = 0;
	int items_sent = 0;
	int cycles = 0;

	always #4 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Result side: random back-pressure, check at the rising edge
	always @(negedge clk) begin
		result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			board.check_answer(result_ch.payload);
	end

	// Send one access item, with random leading gaps
	task automatic send_access(pckm_in_t it);
		while ($urandom_range(0, 99) < gap_pct) begin
			@(negedge clk);
			access_ch.valid <= 1'b0;
		end
		@(negedge clk);
		access_ch.valid   <= 1'b1;
		access_ch.payload <= it;
		do @(posedge clk); while (access_ch.ready !== 1'b1);
		board.note_access(it);
		items_sent++;
	endtask

	// Drop valid and wait for every answer before touching registers
	task automatic settle();
		@(negedge clk);
		access_ch.valid <= 1'b0;
		while (board.due_answers.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [63:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_idx   <= idx;
		cfg_data  <= val;
		@(posedge clk);
		board.write_reg(idx, val);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Fully random access; reset events now and then
	function automatic pckm_in_t any_access();
		pckm_in_t it;
		it.opcode      = ($urandom_range(0, 19) == 0) ? OpReset : OpRead;
		it.address     = 16'($urandom);
		it.rom_data    = 8'($urandom);
		it.now_seconds = 6'($urandom);
		it.now_minutes = 6'($urandom);
		it.now_hours   = 5'($urandom);
		it.now_weekday = 3'($urandom);
		it.now_day     = 5'($urandom);
		it.now_month   = 4'($urandom);
		it.now_year    = 7'($urandom);
		return it;
	endfunction

	function automatic pckm_in_t pick(logic op, logic [15:0] addr, logic [7:0] rom);
		pckm_in_t it = any_access();
		it.opcode   = op;
		it.address  = addr;
		it.rom_data = rom;
		return it;
	endfunction

	// Time fields: 0 all ones (clamped digits), 1 all zero, 2 calendar range, else raw
	function automatic pckm_in_t stamp_time(pckm_in_t it, int mode);
		case (mode)
			0: {it.now_seconds, it.now_minutes, it.now_hours, it.now_weekday,
				it.now_day, it.now_month, it.now_year} = '1;
			1: {it.now_seconds, it.now_minutes, it.now_hours, it.now_weekday,
				it.now_day, it.now_month, it.now_year} = '0;
			2: begin
				it.now_seconds = 6'($urandom_range(0, 60));
				it.now_minutes = 6'($urandom_range(0, 59));
				it.now_hours   = 5'($urandom_range(0, 23));
				it.now_weekday = 3'($urandom_range(0, 6));
				it.now_day     = 5'($urandom_range(1, 31));
				it.now_month   = 4'($urandom_range(1, 12));
				it.now_year    = 7'($urandom_range(0, 99));
			end
			default: ;
		endcase
		return it;
	endfunction

	function automatic pckm_in_t key_access(bit b);
		pckm_in_t it = any_access();
		it.opcode          = OpRead;
		it.address[SelBit] = 1'b0;
		it.address[KeyBit] = b;
		return it;
	endfunction

	// Reopen, shift in the key, then read the clock out; some sequences are broken
	task automatic send_unlock();
		pckm_in_t it;
		int fault_at;
		int readout_len;
		fault_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, KeyLen - 1) : KeyLen;
		it = any_access();
		it.opcode          = OpRead;
		it.address[SelBit] = 1'b1;
		send_access(it);
		for (int i = 0; i < KeyLen; i++) begin
			it = key_access(board.key[i]);
			if (i == fault_at) begin
				if ($urandom_range(0, 1))
					it.address[KeyBit] = ~board.key[i];
				else
					it.opcode = OpReset;
			end
			if (i == KeyLen - 1)
				it = stamp_time(it, $urandom_range(0, 3));
			send_access(it);
			if (i == fault_at + 3)
				return;
		end
		readout_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, KeyLen + 4) : KeyLen;
		for (int i = 0; i < readout_len; i++) begin
			it = any_access();
			it.opcode          = OpRead;
			it.address[SelBit] = ($urandom_range(0, 9) != 0);
			send_access(it);
		end
	endtask

	task automatic run_phase(int n_items, int gap, int stall);
		gap_pct    = gap;
		stall_pct  = stall;
		items_sent = 0;
		while (items_sent < n_items) begin
			if ($urandom_range(0, 9) < 7)
				send_unlock();
			else
				repeat ($urandom_range(3, 15)) send_access(any_access());
		end
	endtask

	initial begin
		pckm_in_t it;
		access_ch.valid   = 1'b0;
		access_ch.payload = '0;
		result_ch.ready   = 1'b0;
		cfg_wr_en         = 1'b0;
		cfg_idx           = RegClockEnabled;
		cfg_data          = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: reset event, reopen, matches, mismatch lockout, ignored bits
		it = stamp_time(pick(OpReset, 16'hFFFF, 8'hFF), 0);
		send_access(it);
		it = stamp_time(pick(OpRead, 16'hFFFF, 8'h00), 1);
		send_access(it);
		send_access(pick(OpRead, 16'hFFFA | 16'(KeyReset[0]), 8'hFF));
		send_access(pick(OpRead, 16'h0000 | 16'(KeyReset[1]), 8'h00));
		send_access(pick(OpRead, 16'hFFFA | {15'b0, ~KeyReset[2]}, 8'h81));
		send_access(pick(OpRead, 16'h0000 | 16'(KeyReset[2]), 8'h7E));
		send_access(pick(OpRead, 16'h0004, 8'hA5));
		send_access(pick(OpRead, 16'h0000 | 16'(KeyReset[0]), 8'h01));
		send_access(pick(OpReset, 16'h0000, 8'h5A));
		send_access(pick(OpRead, 16'hFFF0 | 16'(KeyReset[0]), 8'hFE));
		send_access(pick(OpRead, 16'h0000 | 16'(KeyReset[1]), 8'h3C));
		send_access(pick(OpRead, 16'hFFFF, 8'hC3));

		// Clock disabled: plain pass-through, reset event still clears
		settle();
		write_reg(RegClockEnabled, 64'd0);
		send_access(pick(OpRead, 16'h0000 | 16'(KeyReset[0]), 8'hFF));
		send_access(pick(OpReset, 16'hFFFF, 8'hFF));
		send_access(pick(OpRead, 16'hFFFF, 8'hFF));
		settle();
		write_reg(RegClockEnabled, 64'd1);

		// Random phases over several keys and idle patterns; each phase
		// overshoots its target by part of an unlock sequence
		write_reg(RegUnlockKey, {$urandom, $urandom});
		run_phase(80, 7, 51);
		settle();
		write_reg(RegUnlockKey, '1);
		run_phase(80, 51, 7);
		settle();
		write_reg(RegUnlockKey, '0);
		run_phase(50, 0, 0);
		settle();
		write_reg(RegClockEnabled, 64'd0);
		write_reg(RegUnlockKey, {$urandom, $urandom});
		run_phase(20, 0, 0);

		// Drain and decide
		@(negedge clk);
		access_ch.valid <= 1'b0;
		while (board.due_answers.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (board.mismatches == 0 && board.due_answers.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
